// File: rtl/ifp_pkg.sv
// ----------------------------------------------------------------------------
// ifp_pkg: shared types and constants of the IMU frame parser
// Byte type, configuration register indexes, reset values of the
// configuration registers and the bit positions of the seen set.
// ----------------------------------------------------------------------------
package ifp_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] cfg_idx_t;
  typedef logic [2:0] seen_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_HEADER_BYTE   = 3'd0;
  localparam cfg_idx_t CFG_ACCEL_CODE    = 3'd1;
  localparam cfg_idx_t CFG_GYRO_CODE     = 3'd2;
  localparam cfg_idx_t CFG_ANGLE_CODE    = 3'd3;
  localparam cfg_idx_t CFG_REQUIRED_MASK = 3'd4;

  // Reset values of the configuration registers.
  localparam byte_t RST_HEADER_BYTE   = 8'h55;
  localparam byte_t RST_ACCEL_CODE    = 8'h51;
  localparam byte_t RST_GYRO_CODE     = 8'h52;
  localparam byte_t RST_ANGLE_CODE    = 8'h53;
  localparam seen_t RST_REQUIRED_MASK = 3'd7;

  // Seen set bits.
  localparam seen_t SEEN_ACCEL = 3'b001;
  localparam seen_t SEEN_GYRO  = 3'b010;
  localparam seen_t SEEN_ANGLE = 3'b100;

endpackage

// File: rtl/ifp_cell.sv
// ----------------------------------------------------------------------------
// ifp_cell: one byte cell of the receive window
// Holds one window byte and takes its neighbor's byte on every accepted
// request, so that a row of cells forms the sliding window.
// ----------------------------------------------------------------------------
module ifp_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  ifp_pkg::byte_t d,
  output ifp_pkg::byte_t q
);

  ifp_pkg::byte_t byte_r;

  // Take the neighbor's byte when the window advances.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d;
    end
  end

  assign q = byte_r;

endmodule

// File: rtl/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser: checksummed fixed-length serial frame parser
// Slides a window of FRAME_LEN received bytes through a row of byte cells,
// checks header and modulo-256 checksum when the window is full, and reports
// each valid frame with its type, three signed samples and set completion.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in      | input     | in_valid/in_ready   | in_rx_byte
//  out     | output    | out_valid/out_ready | out_frame_type, out_value_x/y/z,
//          |           |                     | out_set_complete
//  cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One byte is taken per cycle. The check runs on the cells' contents plus
// the arriving byte, so a frame's result is registered at the edge that
// accepts its last byte and shows on the next cycle.
// in_ready is low only while a result is held and out_ready is low.
// Reset (synchronous, active low) empties the window, clears the running
// sum and the seen set, and restores the configuration defaults.
// ----------------------------------------------------------------------------
module imu_frame_parser #(
  parameter int FRAME_LEN = 11
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_frame_type,
  output logic signed [15:0]  out_value_x,
  output logic signed [15:0]  out_value_y,
  output logic signed [15:0]  out_value_z,
  output logic                out_set_complete,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  localparam int NCELL  = FRAME_LEN - 1;
  localparam int FILL_W = $clog2(FRAME_LEN);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FRAME_LEN - 1);

  // Configuration registers.
  ifp_pkg::byte_t header_r, accel_r, gyro_r, angle_r;
  ifp_pkg::seen_t mask_r;

  // Window state.
  ifp_pkg::byte_t        cell_q [NCELL];
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  ifp_pkg::byte_t        sum_r, sum_nxt;
  ifp_pkg::seen_t        seen_r, seen_nxt, seen_upd;

  // Output register.
  logic                  out_valid_r;
  ifp_pkg::byte_t        type_r;
  logic [15:0]           vx_r, vy_r, vz_r;
  logic                  done_r;

  logic accept;
  logic full;
  logic frame_ok;
  logic done;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Row of window cells; the last cell takes the arriving byte.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ifp_pkg::byte_t d;
    if (i == NCELL - 1) begin : g_tail
      assign d = in_rx_byte;
    end else begin : g_link
      assign d = cell_q[i+1];
    end
    ifp_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .d        (d),
      .q        (cell_q[i])
    );
  end

  // Frame check: the cells hold bytes 0..FRAME_LEN-2, the arriving byte is
  // the checksum, and the running sum covers exactly the cells' bytes.
  assign full     = (fill_r == FILL_FULL);
  assign frame_ok = full && (cell_q[0] == header_r) && (sum_r == in_rx_byte);

  // Seen set update and completion test.
  always_comb begin
    seen_upd = seen_r;
    if (cell_q[1] == accel_r) begin
      seen_upd = ifp_pkg::SEEN_ACCEL;
    end else if (cell_q[1] == gyro_r) begin
      seen_upd = seen_r | ifp_pkg::SEEN_GYRO;
    end else if (cell_q[1] == angle_r) begin
      seen_upd = seen_r | ifp_pkg::SEEN_ANGLE;
    end
    done = ((seen_upd & mask_r) == mask_r);
  end

  // Next window state.
  always_comb begin
    fill_nxt = fill_r;
    sum_nxt  = sum_r;
    seen_nxt = seen_r;
    if (accept) begin
      if (frame_ok) begin
        fill_nxt = '0;
        sum_nxt  = '0;
        seen_nxt = done ? '0 : seen_upd;
      end else if (full) begin
        // Drop the oldest byte and keep the window full.
        sum_nxt = sum_r + in_rx_byte - cell_q[0];
      end else begin
        fill_nxt = fill_r + 1'b1;
        sum_nxt  = sum_r + in_rx_byte;
      end
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      sum_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
      header_r    <= ifp_pkg::RST_HEADER_BYTE;
      accel_r     <= ifp_pkg::RST_ACCEL_CODE;
      gyro_r      <= ifp_pkg::RST_GYRO_CODE;
      angle_r     <= ifp_pkg::RST_ANGLE_CODE;
      mask_r      <= ifp_pkg::RST_REQUIRED_MASK;
    end else begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      seen_r <= seen_nxt;
      if (accept && frame_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          ifp_pkg::CFG_HEADER_BYTE:   header_r <= cfg_wdata;
          ifp_pkg::CFG_ACCEL_CODE:    accel_r  <= cfg_wdata;
          ifp_pkg::CFG_GYRO_CODE:     gyro_r   <= cfg_wdata;
          ifp_pkg::CFG_ANGLE_CODE:    angle_r  <= cfg_wdata;
          ifp_pkg::CFG_REQUIRED_MASK: mask_r   <= cfg_wdata[2:0];
          default: ;
        endcase
      end
    end
  end

  // Result payload, loaded with each valid frame.
  always_ff @(posedge clk) begin
    if (accept && frame_ok) begin
      type_r <= cell_q[1];
      vx_r   <= {cell_q[3], cell_q[2]};
      vy_r   <= {cell_q[5], cell_q[4]};
      vz_r   <= {cell_q[7], cell_q[6]};
      done_r <= done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_type   = type_r;
  assign out_value_x      = signed'(vx_r);
  assign out_value_y      = signed'(vy_r);
  assign out_value_z      = signed'(vz_r);
  assign out_set_complete = done_r;

  // The fill count never goes past a full window.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill count out of range");

  // A valid frame empties the window and its running sum.
  a_frame_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_ok |=> fill_r == '0 && sum_r == '0)
    else $error("window not emptied after a valid frame");

  // A completed set leaves the seen set cleared.
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_ok && done |=> seen_r == '0 && out_set_complete)
    else $error("seen set not cleared on completion");

  // A byte into a window that is not full grows it by one.
  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !full |=> fill_r == $past(fill_r) + 1'b1)
    else $error("window fill did not advance");

endmodule
